>>> hw/rtl/ezr_pkg.sv
// ezr_pkg: constants shared by the euler zyx point rotation unit
// holds the cordic gain and arctangent table and the angle conversion constants
// no dependencies
package ezr_pkg;

   localparam int ANG_WIDTH = 26;
   localparam int CZ_WIDTH  = 34;
   localparam int REM_WIDTH = 6;
   localparam int DIV_STEP  = 8;
   localparam int Q_WIDTH   = 32;

   localparam logic [REM_WIDTH:0] DIV_BY     = 7'd45;
   localparam logic [7:0]         ROUND_BIAS = 8'd22;

   localparam logic signed [CZ_WIDTH-1:0] GAIN_Q30     = 34'sh0_26DD_3B6A;
   localparam logic signed [CZ_WIDTH-1:0] QUARTER_TURN = 34'sh0_4000_0000;
   localparam logic signed [CZ_WIDTH-1:0] HALF_TURN    = 34'sh0_8000_0000;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

endpackage

>>> hw/rtl/ezr_if.sv
// ezr_req_if, ezr_rsp_if: valid/ready channels of the rotation unit
// depends on ezr_pkg for the angle width
interface ezr_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                                valid;
   logic                                ready;
   logic signed [COORD_WIDTH-1:0]       in_x;
   logic signed [COORD_WIDTH-1:0]       in_y;
   logic signed [COORD_WIDTH-1:0]       in_z;
   logic signed [ezr_pkg::ANG_WIDTH-1:0] angle_x;
   logic signed [ezr_pkg::ANG_WIDTH-1:0] angle_y;
   logic signed [ezr_pkg::ANG_WIDTH-1:0] angle_z;

   modport source (output valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, input ready);
   modport sink   (input valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, output ready);
   modport monitor (input valid, ready, in_x, in_y, in_z, angle_x, angle_y, angle_z);
endinterface

interface ezr_rsp_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic                          saturated;

   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
   modport monitor (input valid, ready, out_x, out_y, out_z, saturated);
endinterface

>>> hw/rtl/ezr_trig.sv
// ezr_trig: three-lane sine/cosine pipeline, degrees to binary angle then cordic
// carries a payload and valid alongside; depends on ezr_pkg
module ezr_trig #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18,
   parameter int PW            = 96
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 vld_i,
   input  logic signed [ezr_pkg::ANG_WIDTH-1:0] ang_i [3],
   input  logic [PW-1:0]                        pay_i,
   output logic                                 vld_o,
   output logic signed [FRAC_BITS+1:0]          sin_o [3],
   output logic signed [FRAC_BITS+1:0]          cos_o [3],
   output logic [PW-1:0]                        pay_o
);
   localparam int SH  = 29 - FRAC_BITS;
   localparam int E   = (20 + SH > 32) ? 20 + SH : 32;
   localparam int UW  = E + 7;
   localparam int NDS = (UW + ezr_pkg::DIV_STEP - 1) / ezr_pkg::DIV_STEP;
   localparam int DW  = NDS * ezr_pkg::DIV_STEP;
   localparam int NC  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int LT  = NDS + NC + 3;
   localparam int CZ  = ezr_pkg::CZ_WIDTH;
   localparam int TW  = FRAC_BITS + 2;
   localparam int RW  = ezr_pkg::REM_WIDTH;
   localparam int QW  = ezr_pkg::Q_WIDTH;
   localparam logic signed [CZ-1:0] RHALF = 1 <<< (29 - FRAC_BITS);

   logic          vld_ff [LT];
   logic [PW-1:0] pay_ff [LT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LT; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= vld_i;
         for (int k = 1; k < LT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pay_ff[0] <= pay_i;
         for (int k = 1; k < LT; k++) pay_ff[k] <= pay_ff[k-1];
      end
   end

   assign vld_o = vld_ff[LT-1];
   assign pay_o = pay_ff[LT-1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW-1:0]       u_ff;
      logic [DW-1:0]       u_in;
      logic [DW-1:0]       dn_ff [NDS];
      logic [RW-1:0]       dr_ff [NDS];
      logic [QW-1:0]       dq_ff [NDS];
      logic signed [CZ-1:0] fz_ff;
      logic signed [CZ-1:0] fz_in;
      logic                fl_ff;
      logic                fl_in;
      logic signed [CZ-1:0] cx_ff [NC];
      logic signed [CZ-1:0] cy_ff [NC];
      logic signed [CZ-1:0] cz_ff [NC];
      logic                cf_ff [NC];
      logic signed [TW-1:0] s_ff;
      logic signed [TW-1:0] c_ff;
      logic signed [TW-1:0] s_in;
      logic signed [TW-1:0] c_in;

      // degrees times 2^(29-F), plus bias, offset to stay non-negative
      assign u_in = (DW'(ang_i[l]) << SH) + DW'(ezr_pkg::ROUND_BIAS)
                    + (DW'(ezr_pkg::DIV_BY) << E);

      always_ff @(posedge clock) begin
         if (advance) u_ff <= u_in;
      end

      // long division by 45, eight quotient bits per stage
      for (genvar k = 0; k < NDS; k++) begin : g_div
         logic [DW-1:0] n_src;
         logic [RW-1:0] r_src;
         logic [QW-1:0] q_src;
         logic [DW-1:0] n_in;
         logic [RW-1:0] r_in;
         logic [QW-1:0] q_in;

         if (k == 0) begin : g_first
            assign n_src = u_ff;
            assign r_src = '0;
            assign q_src = '0;
         end else begin : g_next
            assign n_src = dn_ff[k-1];
            assign r_src = dr_ff[k-1];
            assign q_src = dq_ff[k-1];
         end

         always_comb begin
            logic [RW:0]   r7;
            logic [RW-1:0] r;
            logic [QW-1:0] q;
            r = r_src;
            q = q_src;
            for (int j = 0; j < ezr_pkg::DIV_STEP; j++) begin
               r7 = {r, n_src[DW-1-j]};
               if (r7 >= ezr_pkg::DIV_BY) begin
                  r7 = r7 - ezr_pkg::DIV_BY;
                  q  = {q[QW-2:0], 1'b1};
               end else begin
                  q  = {q[QW-2:0], 1'b0};
               end
               r = r7[RW-1:0];
            end
            r_in = r;
            q_in = q;
            n_in = n_src << ezr_pkg::DIV_STEP;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               dn_ff[k] <= n_in;
               dr_ff[k] <= r_in;
               dq_ff[k] <= q_in;
            end
         end
      end

      // fold into the right half plane
      always_comb begin
         logic signed [CZ-1:0] z;
         z = CZ'(signed'(dq_ff[NDS-1]));
         fl_in = 1'b0;
         if (z > ezr_pkg::QUARTER_TURN) begin
            z     = z - ezr_pkg::HALF_TURN;
            fl_in = 1'b1;
         end else if (z < -ezr_pkg::QUARTER_TURN) begin
            z     = z + ezr_pkg::HALF_TURN;
            fl_in = 1'b1;
         end
         fz_in = z;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            fz_ff <= fz_in;
            fl_ff <= fl_in;
         end
      end

      for (genvar k = 0; k < NC; k++) begin : g_cordic
         logic signed [CZ-1:0] x_src;
         logic signed [CZ-1:0] y_src;
         logic signed [CZ-1:0] z_src;
         logic                 f_src;
         logic signed [CZ-1:0] x_in;
         logic signed [CZ-1:0] y_in;
         logic signed [CZ-1:0] z_in;
         logic signed [CZ-1:0] at;

         if (k == 0) begin : g_first
            assign x_src = ezr_pkg::GAIN_Q30;
            assign y_src = '0;
            assign z_src = fz_ff;
            assign f_src = fl_ff;
         end else begin : g_next
            assign x_src = cx_ff[k-1];
            assign y_src = cy_ff[k-1];
            assign z_src = cz_ff[k-1];
            assign f_src = cf_ff[k-1];
         end

         assign at = CZ'(ezr_pkg::ATAN_TABLE[k]);

         always_comb begin
            if (!z_src[CZ-1]) begin
               x_in = x_src - (y_src >>> k);
               y_in = y_src + (x_src >>> k);
               z_in = z_src - at;
            end else begin
               x_in = x_src + (y_src >>> k);
               y_in = y_src - (x_src >>> k);
               z_in = z_src + at;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               cx_ff[k] <= x_in;
               cy_ff[k] <= y_in;
               cz_ff[k] <= z_in;
               cf_ff[k] <= f_src;
            end
         end
      end

      // undo the fold, round q30 down to the coordinate fraction
      always_comb begin
         logic signed [CZ-1:0] xr;
         logic signed [CZ-1:0] yr;
         logic signed [CZ-1:0] xs;
         logic signed [CZ-1:0] ys;
         xr = cf_ff[NC-1] ? -cx_ff[NC-1] : cx_ff[NC-1];
         yr = cf_ff[NC-1] ? -cy_ff[NC-1] : cy_ff[NC-1];
         xs = (xr + RHALF) >>> (30 - FRAC_BITS);
         ys = (yr + RHALF) >>> (30 - FRAC_BITS);
         c_in = xs[TW-1:0];
         s_in = ys[TW-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            s_ff <= s_in;
            c_ff <= c_in;
         end
      end

      assign sin_o[l] = s_ff;
      assign cos_o[l] = c_ff;
   end

endmodule

>>> hw/rtl/ezr_rot.sv
// ezr_rot: one plane rotation u' = u*c - v*s, v' = u*s + v*c, two stages
// products rounded half up to the coordinate fraction; no package use
module ezr_rot #(
   parameter int IW        = 34,
   parameter int FRAC_BITS = 16,
   parameter int PW        = 34
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         vld_i,
   input  logic signed [IW-1:0]         u_i,
   input  logic signed [IW-1:0]         v_i,
   input  logic signed [FRAC_BITS+1:0]  s_i,
   input  logic signed [FRAC_BITS+1:0]  c_i,
   input  logic [PW-1:0]                pay_i,
   output logic                         vld_o,
   output logic signed [IW-1:0]         u_o,
   output logic signed [IW-1:0]         v_o,
   output logic [PW-1:0]                pay_o
);
   localparam int PD = IW + FRAC_BITS + 2;
   localparam logic signed [PD-1:0] HALF = 1 <<< (FRAC_BITS - 1);

   logic signed [PD-1:0] uc_ff, vs_ff, us_ff, vc_ff;
   logic signed [IW-1:0] u_ff, v_ff;
   logic signed [IW-1:0] u_in, v_in;
   logic [PW-1:0]        p1_ff, p2_ff;
   logic                 v1_ff, v2_ff;

   function automatic logic signed [IW-1:0] rnd(input logic signed [PD-1:0] p);
      logic signed [PD-1:0] t;
      t = (p + HALF) >>> FRAC_BITS;
      return t[IW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         uc_ff <= PD'(u_i) * PD'(c_i);
         vs_ff <= PD'(v_i) * PD'(s_i);
         us_ff <= PD'(u_i) * PD'(s_i);
         vc_ff <= PD'(v_i) * PD'(c_i);
         p1_ff <= pay_i;
      end
   end

   assign u_in = rnd(uc_ff) - rnd(vs_ff);
   assign v_in = rnd(us_ff) + rnd(vc_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         p2_ff <= p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= vld_i;
         v2_ff <= v1_ff;
      end
   end

   assign vld_o = v2_ff;
   assign u_o   = u_ff;
   assign v_o   = v_ff;
   assign pay_o = p2_ff;

endmodule

>>> hw/rtl/euler_zyx_point_rotation_unit.sv
// euler_zyx_point_rotation_unit: top level, trig pipeline, three rotations, clip
// depends on ezr_pkg, ezr_if, ezr_trig, ezr_rot
//
// Rotates a fixed-point 3D point about Z, then Y, then X by angles in degrees.
// One point enters per clock cycle while the output is not stalled. The pipeline depth
// is set by the long division by 45 that turns degrees into a binary angle, eight
// bits per stage, and by the CORDIC chain, one iteration per stage; each rotation
// takes a multiply and an add stage. The whole pipeline advances together: while a
// result waits at the output, nothing moves and no new point is taken.
module euler_zyx_point_rotation_unit #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic       clock,
   input  logic       reset,
   ezr_req_if.sink    req_ch,
   ezr_rsp_if.source  rsp_ch
);
   localparam int CW = COORD_WIDTH;
   localparam int IW = COORD_WIDTH + 2;
   localparam int TW = FRAC_BITS + 2;

   localparam logic signed [IW-1:0] HI_V = {3'b000, {(CW-1){1'b1}}};
   localparam logic signed [IW-1:0] LO_V = {3'b111, {(CW-1){1'b0}}};

   logic advance;

   logic                                 t_vld;
   logic signed [ezr_pkg::ANG_WIDTH-1:0] angs [3];
   logic signed [TW-1:0]                 t_sin [3];
   logic signed [TW-1:0]                 t_cos [3];
   logic [3*CW-1:0]                      t_pay;

   logic signed [IW-1:0] x0, y0, z0;

   logic                      rz_vld;
   logic signed [IW-1:0]      rz_x, rz_y;
   logic [IW+4*TW-1:0]        rz_pay;
   logic signed [IW-1:0]      rz_z;
   logic signed [TW-1:0]      rz_sy, rz_cy, rz_sx, rz_cx;

   logic                      ry_vld;
   logic signed [IW-1:0]      ry_z, ry_x;
   logic [IW+2*TW-1:0]        ry_pay;
   logic signed [IW-1:0]      ry_y;
   logic signed [TW-1:0]      ry_sx, ry_cx;

   logic                      rx_vld;
   logic signed [IW-1:0]      rx_y, rx_z;
   logic [IW-1:0]             rx_pay;
   logic signed [IW-1:0]      rx_x;

   logic                  out_vld_ff;
   logic signed [CW-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic                  out_sat_ff;
   logic signed [CW-1:0]  out_x_in, out_y_in, out_z_in;
   logic                  out_sat_in;

   assign advance      = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign angs[0] = req_ch.angle_x;
   assign angs[1] = req_ch.angle_y;
   assign angs[2] = req_ch.angle_z;

   ezr_trig #(
      .FRAC_BITS     (FRAC_BITS),
      .CORDIC_STAGES (CORDIC_STAGES),
      .PW            (3*CW)
   ) u_trig (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .vld_i   (req_ch.valid),
      .ang_i   (angs),
      .pay_i   ({req_ch.in_z, req_ch.in_y, req_ch.in_x}),
      .vld_o   (t_vld),
      .sin_o   (t_sin),
      .cos_o   (t_cos),
      .pay_o   (t_pay)
   );

   assign x0 = IW'(signed'(t_pay[CW-1:0]));
   assign y0 = IW'(signed'(t_pay[2*CW-1:CW]));
   assign z0 = IW'(signed'(t_pay[3*CW-1:2*CW]));

   // rotation about z
   ezr_rot #(.IW(IW), .FRAC_BITS(FRAC_BITS), .PW(IW+4*TW)) u_rot_z (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .vld_i   (t_vld),
      .u_i     (x0),
      .v_i     (y0),
      .s_i     (t_sin[2]),
      .c_i     (t_cos[2]),
      .pay_i   ({z0, t_sin[1], t_cos[1], t_sin[0], t_cos[0]}),
      .vld_o   (rz_vld),
      .u_o     (rz_x),
      .v_o     (rz_y),
      .pay_o   (rz_pay)
   );

   assign rz_cx = rz_pay[TW-1:0];
   assign rz_sx = rz_pay[2*TW-1:TW];
   assign rz_cy = rz_pay[3*TW-1:2*TW];
   assign rz_sy = rz_pay[4*TW-1:3*TW];
   assign rz_z  = rz_pay[IW+4*TW-1:4*TW];

   // rotation about y
   ezr_rot #(.IW(IW), .FRAC_BITS(FRAC_BITS), .PW(IW+2*TW)) u_rot_y (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .vld_i   (rz_vld),
      .u_i     (rz_z),
      .v_i     (rz_x),
      .s_i     (rz_sy),
      .c_i     (rz_cy),
      .pay_i   ({rz_y, rz_sx, rz_cx}),
      .vld_o   (ry_vld),
      .u_o     (ry_z),
      .v_o     (ry_x),
      .pay_o   (ry_pay)
   );

   assign ry_cx = ry_pay[TW-1:0];
   assign ry_sx = ry_pay[2*TW-1:TW];
   assign ry_y  = ry_pay[IW+2*TW-1:2*TW];

   // rotation about x
   ezr_rot #(.IW(IW), .FRAC_BITS(FRAC_BITS), .PW(IW)) u_rot_x (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .vld_i   (ry_vld),
      .u_i     (ry_y),
      .v_i     (ry_z),
      .s_i     (ry_sx),
      .c_i     (ry_cx),
      .pay_i   (ry_x),
      .vld_o   (rx_vld),
      .u_o     (rx_y),
      .v_o     (rx_z),
      .pay_o   (rx_pay)
   );

   assign rx_x = rx_pay;

   // clip each axis to the coordinate range
   always_comb begin
      out_sat_in = 1'b0;
      if (rx_x > HI_V) begin
         out_x_in = HI_V[CW-1:0];
         out_sat_in = 1'b1;
      end else if (rx_x < LO_V) begin
         out_x_in = LO_V[CW-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_x_in = rx_x[CW-1:0];
      end
      if (rx_y > HI_V) begin
         out_y_in = HI_V[CW-1:0];
         out_sat_in = 1'b1;
      end else if (rx_y < LO_V) begin
         out_y_in = LO_V[CW-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_y_in = rx_y[CW-1:0];
      end
      if (rx_z > HI_V) begin
         out_z_in = HI_V[CW-1:0];
         out_sat_in = 1'b1;
      end else if (rx_z < LO_V) begin
         out_z_in = LO_V[CW-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_z_in = rx_z[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= rx_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_z_ff   <= out_z_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.out_x     = out_x_ff;
   assign rsp_ch.out_y     = out_y_ff;
   assign rsp_ch.out_z     = out_z_ff;
   assign rsp_ch.saturated = out_sat_ff;

   // a clipped result has at least one axis at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_sat_ff |->
         out_x_ff == HI_V[CW-1:0] || out_x_ff == LO_V[CW-1:0] ||
         out_y_ff == HI_V[CW-1:0] || out_y_ff == LO_V[CW-1:0] ||
         out_z_ff == HI_V[CW-1:0] || out_z_ff == LO_V[CW-1:0])
      else $error("saturated flag without a clipped axis");

   // a stalled output freezes the pipeline and blocks intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while output stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_vld_ff)
      else $error("output valid right after reset");

endmodule
